/* sv/sdsw_pkg.sv */
// Shared types, constants and the segment font for the serial display writer.
// Depends on nothing; every other file of the block imports it.
package sdsw_pkg;

    // Default number of stored digit bytes.
    localparam int DIGITS_DEFAULT = 4;

    // Widths fixed by the word fields.
    localparam int CNT_W  = 3;
    localparam int POS_W  = 2;
    localparam int BYTE_W = 8;
    localparam int LVL_W  = 3;
    localparam int IDX_W  = 3;

    // Number of digit inputs carried by one request word.
    localparam int DIGIT_INPUTS = 4;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] CFG_BRIGHTNESS = 3'd0;
    localparam logic [IDX_W-1:0] CFG_DISPLAY_ON = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DATA_CMD   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_ADDR_CMD   = 3'd3;
    localparam logic [IDX_W-1:0] CFG_CTRL_CMD   = 3'd4;

    // Configuration reset values.
    localparam logic [LVL_W-1:0]  RST_BRIGHTNESS = 3'd7;
    localparam logic              RST_DISPLAY_ON = 1'b1;
    localparam logic [BYTE_W-1:0] RST_DATA_CMD   = 8'h40;
    localparam logic [BYTE_W-1:0] RST_ADDR_CMD   = 8'hC0;
    localparam logic [BYTE_W-1:0] RST_CTRL_CMD   = 8'h80;

    // Word kinds.
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    // One input word.
    typedef struct packed {
        logic                                     kind;
        logic                                     line_in;
        logic [DIGIT_INPUTS-1:0][BYTE_W-1:0]      digit;
        logic                                     translate;
        logic [CNT_W-1:0]                         digit_count;
        logic [POS_W-1:0]                         position;
    } t_sdsw_item;

    // One result word.
    typedef struct packed {
        logic clk_low;
        logic dio_low;
        logic busy_res;
        logic accepted;
        logic nack_seen;
        logic done_res;
    } t_sdsw_result;

    // Configuration register contents.
    typedef struct packed {
        logic [LVL_W-1:0]  brightness_level;
        logic              display_on;
        logic [BYTE_W-1:0] data_command;
        logic [BYTE_W-1:0] address_command;
        logic [BYTE_W-1:0] control_command;
    } t_sdsw_cfg;

    // Seven-segment font for codes 0..35; other codes are blank.
    function automatic logic [BYTE_W-1:0] seg_font(input logic [BYTE_W-1:0] code);
        logic [BYTE_W-1:0] seg;
        case (code)
            8'd0:  seg = 8'h3F;
            8'd1:  seg = 8'h06;
            8'd2:  seg = 8'h5B;
            8'd3:  seg = 8'h4F;
            8'd4:  seg = 8'h66;
            8'd5:  seg = 8'h6D;
            8'd6:  seg = 8'h7D;
            8'd7:  seg = 8'h07;
            8'd8:  seg = 8'h7F;
            8'd9:  seg = 8'h6F;
            8'd10: seg = 8'h77;
            8'd11: seg = 8'h7C;
            8'd12: seg = 8'h39;
            8'd13: seg = 8'h5E;
            8'd14: seg = 8'h79;
            8'd15: seg = 8'h71;
            8'd16: seg = 8'h3C;
            8'd17: seg = 8'h7C;
            8'd18: seg = 8'h30;
            8'd19: seg = 8'h1E;
            8'd20: seg = 8'h75;
            8'd21: seg = 8'h38;
            8'd22: seg = 8'h15;
            8'd23: seg = 8'h37;
            8'd24: seg = 8'h5C;
            8'd25: seg = 8'h73;
            8'd26: seg = 8'h67;
            8'd27: seg = 8'h33;
            8'd28: seg = 8'h6D;
            8'd29: seg = 8'h78;
            8'd30: seg = 8'h3E;
            8'd31: seg = 8'h2E;
            8'd32: seg = 8'h2A;
            8'd33: seg = 8'h76;
            8'd34: seg = 8'h6E;
            8'd35: seg = 8'h4B;
            default: seg = 8'h00;
        endcase
        return seg;
    endfunction

endpackage

/* sv/sdsw_seq.sv */
// Line sequencer of the serial display writer: holds the update state and
// advances it by one word per step. Depends on sdsw_pkg.
module sdsw_seq #(
    parameter int DIGITS = sdsw_pkg::DIGITS_DEFAULT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_step,
    input  sdsw_pkg::t_sdsw_item    i_item,
    input  sdsw_pkg::t_sdsw_cfg     i_cfg,
    output sdsw_pkg::t_sdsw_result  o_result
);
    import sdsw_pkg::*;

    localparam int SEL_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [CNT_W-1:0] DIG_CNT = CNT_W'(DIGITS);
    localparam logic [3:0] ACK_OK   = 4'd8;
    localparam logic [3:0] ACK_MISS = 4'd9;

    // One-hot line phases.
    typedef enum logic [10:0] {
        PH_START    = 11'b000_0000_0001,
        PH_BIT_LOW  = 11'b000_0000_0010,
        PH_BIT_DATA = 11'b000_0000_0100,
        PH_BIT_HIGH = 11'b000_0000_1000,
        PH_ACK_LOW  = 11'b000_0001_0000,
        PH_ACK_SAMP = 11'b000_0010_0000,
        PH_ACK_DRV  = 11'b000_0100_0000,
        PH_ACK_END  = 11'b000_1000_0000,
        PH_STOP_DAT = 11'b001_0000_0000,
        PH_STOP_CLK = 11'b010_0000_0000,
        PH_STOP_END = 11'b100_0000_0000
    } t_phase;

    t_phase              r_phase, n_phase;
    logic [3:0]          r_bit_count, n_bit_count;
    logic [2:0]          r_byte_index, n_byte_index;
    logic [1:0]          r_tx, n_tx;
    logic [BYTE_W-1:0]   r_shift, n_shift;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_busy, n_busy;
    logic                r_nack, n_nack;
    logic                r_clk_drv, n_clk_drv;
    logic                r_dio_drv, n_dio_drv;
    logic [BYTE_W-1:0]   r_store [DIGITS];
    logic [BYTE_W-1:0]   n_store [DIGITS];

    logic [BYTE_W-1:0]   first_byte;
    logic                acc;
    logic                done;
    logic [CNT_W-1:0]    req_count;

    // Opening byte of the current transaction.
    always_comb begin
        case (r_tx)
            2'd0:    first_byte = i_cfg.data_command;
            2'd1:    first_byte = i_cfg.address_command + {{(BYTE_W-POS_W){1'b0}}, r_pos};
            default: first_byte = i_cfg.control_command +
                                  {4'b0000, i_cfg.display_on, i_cfg.brightness_level};
        endcase
    end

    // Requested digit count, saturated to the store depth.
    assign req_count = (i_item.digit_count > DIG_CNT) ? DIG_CNT : i_item.digit_count;

    // Next-state logic for one word.
    always_comb begin
        n_phase      = r_phase;
        n_bit_count  = r_bit_count;
        n_byte_index = r_byte_index;
        n_tx         = r_tx;
        n_shift      = r_shift;
        n_count      = r_count;
        n_pos        = r_pos;
        n_busy       = r_busy;
        n_nack       = r_nack;
        n_clk_drv    = r_clk_drv;
        n_dio_drv    = r_dio_drv;
        acc          = 1'b0;
        done         = 1'b0;
        for (int i = 0; i < DIGITS; i++) begin
            n_store[i] = r_store[i];
        end

        if (i_item.kind == KIND_REQUEST) begin
            // A request is taken only while idle.
            if (!r_busy) begin
                for (int i = 0; i < DIGITS; i++) begin
                    if (i < DIGIT_INPUTS) begin
                        n_store[i] = i_item.translate ? seg_font(i_item.digit[i])
                                                      : i_item.digit[i];
                    end else begin
                        n_store[i] = '0;
                    end
                end
                n_count      = req_count;
                n_pos        = i_item.position;
                n_busy       = 1'b1;
                n_nack       = 1'b0;
                n_phase      = PH_START;
                n_bit_count  = '0;
                n_byte_index = '0;
                n_tx         = '0;
                acc          = 1'b1;
            end
        end else if (r_busy) begin
            case (r_phase)
                PH_START: begin
                    n_dio_drv    = 1'b1;
                    n_shift      = first_byte;
                    n_byte_index = '0;
                    n_bit_count  = '0;
                    n_phase      = PH_BIT_LOW;
                end
                PH_BIT_LOW: begin
                    n_clk_drv = 1'b1;
                    n_phase   = PH_BIT_DATA;
                end
                PH_BIT_DATA: begin
                    n_dio_drv = ~r_shift[0];
                    n_phase   = PH_BIT_HIGH;
                end
                PH_BIT_HIGH: begin
                    n_clk_drv   = 1'b0;
                    n_shift     = r_shift >> 1;
                    n_bit_count = r_bit_count + 4'd1;
                    n_phase     = (n_bit_count >= ACK_OK) ? PH_ACK_LOW : PH_BIT_LOW;
                end
                PH_ACK_LOW: begin
                    n_clk_drv = 1'b1;
                    n_dio_drv = 1'b0;
                    n_phase   = PH_ACK_SAMP;
                end
                PH_ACK_SAMP: begin
                    // The receiver pulls the data line low to acknowledge.
                    n_clk_drv = 1'b0;
                    if (i_item.line_in) begin
                        n_nack = 1'b1;
                    end
                    n_bit_count = i_item.line_in ? ACK_MISS : ACK_OK;
                    n_phase     = PH_ACK_DRV;
                end
                PH_ACK_DRV: begin
                    if (r_bit_count == ACK_OK) begin
                        n_dio_drv = 1'b1;
                    end
                    n_phase = PH_ACK_END;
                end
                PH_ACK_END: begin
                    // More digit bytes follow the address byte.
                    n_clk_drv    = 1'b1;
                    n_byte_index = r_byte_index + 3'd1;
                    if (r_tx == 2'd1 && r_byte_index != 3'd7 &&
                        n_byte_index <= r_count && r_byte_index < DIG_CNT) begin
                        n_shift     = r_store[r_byte_index[SEL_W-1:0]];
                        n_bit_count = '0;
                        n_phase     = PH_BIT_LOW;
                    end else begin
                        n_phase = PH_STOP_DAT;
                    end
                end
                PH_STOP_CLK: begin
                    n_clk_drv = 1'b0;
                    n_phase   = PH_STOP_END;
                end
                PH_STOP_END: begin
                    n_dio_drv = 1'b0;
                    n_phase   = PH_START;
                    if (r_tx >= 2'd2) begin
                        n_tx   = '0;
                        n_busy = 1'b0;
                        done   = 1'b1;
                    end else begin
                        n_tx = r_tx + 2'd1;
                    end
                end
                default: begin
                    // First stop phase: data low before the clock rises.
                    n_dio_drv = 1'b1;
                    n_phase   = PH_STOP_CLK;
                end
            endcase
        end
    end

    // Result word of this step.
    always_comb begin
        o_result.clk_low   = n_clk_drv;
        o_result.dio_low   = n_dio_drv;
        o_result.busy_res  = n_busy;
        o_result.accepted  = acc;
        o_result.nack_seen = n_nack;
        o_result.done_res  = done;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_START;
            r_bit_count  <= '0;
            r_byte_index <= '0;
            r_tx         <= '0;
            r_shift      <= '0;
            r_count      <= '0;
            r_pos        <= '0;
            r_busy       <= 1'b0;
            r_nack       <= 1'b0;
            r_clk_drv    <= 1'b0;
            r_dio_drv    <= 1'b0;
        end else if (i_step) begin
            r_phase      <= n_phase;
            r_bit_count  <= n_bit_count;
            r_byte_index <= n_byte_index;
            r_tx         <= n_tx;
            r_shift      <= n_shift;
            r_count      <= n_count;
            r_pos        <= n_pos;
            r_busy       <= n_busy;
            r_nack       <= n_nack;
            r_clk_drv    <= n_clk_drv;
            r_dio_drv    <= n_dio_drv;
        end
    end

    // Digit store, payload only.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            for (int i = 0; i < DIGITS; i++) begin
                r_store[i] <= n_store[i];
            end
        end
    end

endmodule

/* sv/segment_display_serial_writer.sv */
// Top level of the serial display writer; depends on sdsw_pkg and sdsw_seq.
// A word waits in the input register and goes through the sequencer into the
// result register when that is free. Throughput: one word per cycle while the
// output does not stall, one per step in the sequencer. Each tick word of a
// running update moves the open-drain lines by one phase. Reset (synchronous,
// active low) clears the sequencer, releases both lines, empties the word registers.
module segment_display_serial_writer #(
    parameter int DIGITS = sdsw_pkg::DIGITS_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input word channel.
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic        i_line_in,
    input  logic [7:0]  i_digit_zero,
    input  logic [7:0]  i_digit_one,
    input  logic [7:0]  i_digit_two,
    input  logic [7:0]  i_digit_three,
    input  logic        i_translate,
    input  logic [2:0]  i_digit_count,
    input  logic [1:0]  i_position,
    // Result word channel.
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_clk_low,
    output logic        o_dio_low,
    output logic        o_busy_res,
    output logic        o_accepted,
    output logic        o_nack_seen,
    output logic        o_done_res,
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import sdsw_pkg::*;

    logic          r_in_valid;
    t_sdsw_item    r_in_item;
    logic          r_out_valid;
    t_sdsw_result  r_out_res;
    t_sdsw_cfg     r_cfg;
    t_sdsw_result  step_res;
    logic          out_free;
    logic          step;
    logic          in_take;

    // Pipeline handshake.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.kind        <= i_kind;
            r_in_item.line_in     <= i_line_in;
            r_in_item.digit[0]    <= i_digit_zero;
            r_in_item.digit[1]    <= i_digit_one;
            r_in_item.digit[2]    <= i_digit_two;
            r_in_item.digit[3]    <= i_digit_three;
            r_in_item.translate   <= i_translate;
            r_in_item.digit_count <= i_digit_count;
            r_in_item.position    <= i_position;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.brightness_level <= RST_BRIGHTNESS;
            r_cfg.display_on       <= RST_DISPLAY_ON;
            r_cfg.data_command     <= RST_DATA_CMD;
            r_cfg.address_command  <= RST_ADDR_CMD;
            r_cfg.control_command  <= RST_CTRL_CMD;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BRIGHTNESS: r_cfg.brightness_level <= i_cfg_data[LVL_W-1:0];
                CFG_DISPLAY_ON: r_cfg.display_on       <= i_cfg_data[0];
                CFG_DATA_CMD:   r_cfg.data_command     <= i_cfg_data;
                CFG_ADDR_CMD:   r_cfg.address_command  <= i_cfg_data;
                CFG_CTRL_CMD:   r_cfg.control_command  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Line sequencer.
    sdsw_seq #(
        .DIGITS(DIGITS)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (step_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_res <= step_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_clk_low   = r_out_res.clk_low;
    assign o_dio_low   = r_out_res.dio_low;
    assign o_busy_res  = r_out_res.busy_res;
    assign o_accepted  = r_out_res.accepted;
    assign o_nack_seen = r_out_res.nack_seen;
    assign o_done_res  = r_out_res.done_res;

    // The final stop always leaves the writer idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_done_res |-> !o_busy_res)
        else $error("done word reports busy");

    // A taken request starts busy with a clean acknowledge flag.
    a_accept_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_accepted |-> o_busy_res && !o_nack_seen && !o_done_res)
        else $error("accepted request has wrong status");

    // A held result with a full input register must push back on the input.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall && r_in_valid |-> o_in_stall)
        else $error("input not stalled while result is held");

endmodule

/* verif/segment_display_serial_writer_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the segment display serial writer: a directed table
// and random display updates, each result word checked against its table row or
// the in-bench line model. Depends on sdsw_pkg and segment_display_serial_writer.
module segment_display_serial_writer_tb;
    import sdsw_pkg::*;

    localparam int ITEM_TARGET     = 1400;
    localparam int PHASES          = 5;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int MAX_REPORTS     = 10;
    localparam int WATCHDOG_NS     = 5_000_000;
    localparam int REGISTERS       = 5;

    // Line sequencer phases; the first stop phase has no case of its own.
    typedef enum logic [3:0] {
        PH_START             = 4'd0,
        PH_CLK_LOW           = 4'd1,
        PH_SET_DATA          = 4'd2,
        PH_CLK_RELEASE       = 4'd3,
        PH_ACK_CLK_LOW       = 4'd4,
        PH_ACK_SAMPLE        = 4'd5,
        PH_ACK_DRIVE         = 4'd6,
        PH_ACK_END           = 4'd7,
        PH_STOP_DATA_LOW     = 4'd8,
        PH_STOP_CLK_RELEASE  = 4'd9,
        PH_STOP_DATA_RELEASE = 4'd10
    } t_line_phase;

    // Transactions of one update.
    localparam logic [1:0] FRAME_DATA = 2'd0;
    localparam logic [1:0] FRAME_ADDR = 2'd1;
    localparam logic [1:0] FRAME_CTRL = 2'd2;

    // Seven-segment glyphs for codes 0..35.
    localparam logic [7:0] SEGMENT_GLYPHS [36] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
        8'h77, 8'h7C, 8'h39, 8'h5E, 8'h79, 8'h71, 8'h3C, 8'h7C, 8'h30, 8'h1E,
        8'h75, 8'h38, 8'h15, 8'h37, 8'h5C, 8'h73, 8'h67, 8'h33, 8'h6D, 8'h78,
        8'h3E, 8'h2E, 8'h2A, 8'h76, 8'h6E, 8'h4B
    };

    localparam logic [IDX_W-1:0] REGISTER_ORDER [REGISTERS] = '{
        CFG_BRIGHTNESS, CFG_DISPLAY_ON, CFG_DATA_CMD, CFG_ADDR_CMD, CFG_CTRL_CMD
    };

    // One row of the directed table. Digits run from digit three down to digit zero.
    // A repeat count of zero sends ticks until the running update ends.
    typedef struct packed {
        logic         kind;
        logic         line_in;
        logic [31:0]  digits;
        logic         translate;
        logic [2:0]   digit_count;
        logic [1:0]   position;
        logic [7:0]   repeats;
        logic         typed;
        t_sdsw_result want;
    } t_script_row;

    localparam int DIRECTED_ROWS = 13;
    // Expected bits in order: clk dio busy accepted nack done.
    localparam t_script_row DIRECTED_STEPS [DIRECTED_ROWS] = '{
        // Idle ticks after reset leave both lines released.
        '{KIND_TICK,    1'b0, 32'h0000_0000, 1'b0, 3'd0, 2'd0, 8'd1, 1'b1, 6'b000000},
        '{KIND_TICK,    1'b1, 32'hFFFF_FFFF, 1'b1, 3'd7, 2'd3, 8'd2, 1'b1, 6'b000000},
        // Codes 0, 35, 36 and 255 through the font; count above the digit store.
        '{KIND_REQUEST, 1'b1, 32'hFF24_2300, 1'b1, 3'd7, 2'd3, 8'd1, 1'b1, 6'b001100},
        // A request while busy is refused.
        '{KIND_REQUEST, 1'b0, 32'h0102_0304, 1'b0, 3'd1, 2'd0, 8'd1, 1'b1, 6'b001000},
        // Start condition pulls the data line low.
        '{KIND_TICK,    1'b0, 32'h0000_0000, 1'b0, 3'd0, 2'd0, 8'd1, 1'b1, 6'b011000},
        '{KIND_TICK,    1'b0, 32'h0000_0000, 1'b0, 3'd0, 2'd0, 8'd0, 1'b0, 6'b000000},
        // Raw segment bytes at position one.
        '{KIND_REQUEST, 1'b1, 32'h5AA5_00FF, 1'b0, 3'd4, 2'd1, 8'd1, 1'b1, 6'b001100},
        // No byte of this update is acknowledged.
        '{KIND_TICK,    1'b1, 32'hFFFF_FFFF, 1'b1, 3'd7, 2'd3, 8'd0, 1'b0, 6'b000000},
        // Zero digits; the new update clears the missing acknowledge flag.
        '{KIND_REQUEST, 1'b0, 32'h1110_0908, 1'b1, 3'd0, 2'd2, 8'd1, 1'b1, 6'b001100},
        '{KIND_TICK,    1'b0, 32'h0000_0000, 1'b0, 3'd0, 2'd0, 8'd0, 1'b0, 6'b000000},
        '{KIND_REQUEST, 1'b0, 32'h0000_0080, 1'b0, 3'd1, 2'd0, 8'd1, 1'b1, 6'b001100},
        '{KIND_TICK,    1'b0, 32'h0000_0000, 1'b0, 3'd0, 2'd0, 8'd0, 1'b0, 6'b000000},
        // Tick after the final stop: idle again.
        '{KIND_TICK,    1'b0, 32'h0000_0000, 1'b0, 3'd0, 2'd0, 8'd1, 1'b1, 6'b000000}
    };

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_kind;
    logic       i_line_in;
    logic [7:0] i_digit_zero;
    logic [7:0] i_digit_one;
    logic [7:0] i_digit_two;
    logic [7:0] i_digit_three;
    logic       i_translate;
    logic [2:0] i_digit_count;
    logic [1:0] i_position;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_clk_low;
    logic       o_dio_low;
    logic       o_busy_res;
    logic       o_accepted;
    logic       o_nack_seen;
    logic       o_done_res;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [2:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    segment_display_serial_writer dut (.*);

    // Line model state.
    t_sdsw_cfg   disp_cfg;
    logic [7:0]  latched_digits [DIGITS_DEFAULT];
    t_line_phase line_phase;
    logic [3:0]  bits_sent;
    logic [2:0]  bytes_sent;
    logic [1:0]  frame_idx;
    logic [7:0]  out_byte;
    logic [2:0]  latched_count;
    logic [1:0]  latched_pos;
    logic        seq_busy;
    logic        nack_sticky;
    logic        clk_pull;
    logic        dio_pull;

    t_sdsw_result line_words_due [$];

    int  sender_idle_pct = 0;
    int  recv_stall_pct  = 0;
    bit  hold_off_request = 1'b0;
    int  hold_offs = 0;
    int  live_words = 0;
    int  words_sent = 0;
    int  updates_finished = 0;
    int  nack_updates = 0;
    int  settings_loaded = 0;
    int  words_checked = 0;
    int  word_errors = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic [7:0] glyph_for(input logic [7:0] code, input logic translate);
        if (!translate)
            return code;
        if (code < 8'd36)
            return SEGMENT_GLYPHS[code];
        return 8'h00;
    endfunction

    // First byte of the current transaction.
    function automatic logic [7:0] frame_head_byte();
        case (frame_idx)
            FRAME_DATA: return disp_cfg.data_command;
            FRAME_ADDR: return disp_cfg.address_command + {6'd0, latched_pos};
            default: return disp_cfg.control_command
                          + {4'd0, disp_cfg.display_on, disp_cfg.brightness_level};
        endcase
    endfunction

    function automatic void apply_register(input logic [IDX_W-1:0] idx,
                                           input logic [7:0] data);
        case (idx)
            CFG_BRIGHTNESS: disp_cfg.brightness_level = data[2:0];
            CFG_DISPLAY_ON: disp_cfg.display_on = data[0];
            CFG_DATA_CMD:   disp_cfg.data_command = data;
            CFG_ADDR_CMD:   disp_cfg.address_command = data;
            CFG_CTRL_CMD:   disp_cfg.control_command = data;
            default: ;
        endcase
    endfunction

    function automatic void clear_line_model();
        disp_cfg.brightness_level = RST_BRIGHTNESS;
        disp_cfg.display_on = RST_DISPLAY_ON;
        disp_cfg.data_command = RST_DATA_CMD;
        disp_cfg.address_command = RST_ADDR_CMD;
        disp_cfg.control_command = RST_CTRL_CMD;
        for (int i = 0; i < DIGITS_DEFAULT; i++)
            latched_digits[i] = 8'h00;
        line_phase = PH_START;
        bits_sent = '0;
        bytes_sent = '0;
        frame_idx = FRAME_DATA;
        out_byte = '0;
        latched_count = '0;
        latched_pos = '0;
        seq_busy = 1'b0;
        nack_sticky = 1'b0;
        clk_pull = 1'b0;
        dio_pull = 1'b0;
    endfunction

    // Moves the line model by one word and returns the result word it gives.
    function automatic t_sdsw_result advance_line_sequencer(input t_sdsw_item w);
        t_sdsw_result r;
        logic took;
        logic finished;
        took = 1'b0;
        finished = 1'b0;
        if (w.kind == KIND_REQUEST) begin
            if (!seq_busy) begin
                for (int i = 0; i < DIGITS_DEFAULT; i++)
                    latched_digits[i] = glyph_for(w.digit[i], w.translate);
                if (w.digit_count > 3'(DIGITS_DEFAULT))
                    latched_count = 3'(DIGITS_DEFAULT);
                else
                    latched_count = w.digit_count;
                latched_pos = w.position;
                seq_busy = 1'b1;
                nack_sticky = 1'b0;
                line_phase = PH_START;
                bits_sent = '0;
                bytes_sent = '0;
                frame_idx = FRAME_DATA;
                took = 1'b1;
            end
        end else if (seq_busy) begin
            case (line_phase)
                PH_START: begin
                    dio_pull = 1'b1;
                    out_byte = frame_head_byte();
                    bytes_sent = '0;
                    bits_sent = '0;
                    line_phase = PH_CLK_LOW;
                end
                PH_CLK_LOW: begin
                    clk_pull = 1'b1;
                    line_phase = PH_SET_DATA;
                end
                PH_SET_DATA: begin
                    dio_pull = !out_byte[0];
                    line_phase = PH_CLK_RELEASE;
                end
                PH_CLK_RELEASE: begin
                    clk_pull = 1'b0;
                    out_byte = out_byte >> 1;
                    bits_sent = bits_sent + 4'd1;
                    if (bits_sent >= 4'd8)
                        line_phase = PH_ACK_CLK_LOW;
                    else
                        line_phase = PH_CLK_LOW;
                end
                PH_ACK_CLK_LOW: begin
                    clk_pull = 1'b1;
                    dio_pull = 1'b0;
                    line_phase = PH_ACK_SAMPLE;
                end
                // The acknowledge result waits in the bit counter: 8 seen, 9 missing.
                PH_ACK_SAMPLE: begin
                    clk_pull = 1'b0;
                    if (w.line_in)
                        nack_sticky = 1'b1;
                    bits_sent = w.line_in ? 4'd9 : 4'd8;
                    line_phase = PH_ACK_DRIVE;
                end
                PH_ACK_DRIVE: begin
                    if (bits_sent == 4'd8)
                        dio_pull = 1'b1;
                    line_phase = PH_ACK_END;
                end
                // Digit bytes follow the address byte only.
                PH_ACK_END: begin
                    clk_pull = 1'b1;
                    bytes_sent = bytes_sent + 3'd1;
                    if (frame_idx == FRAME_ADDR && bytes_sent >= 3'd1
                            && bytes_sent <= latched_count
                            && int'(bytes_sent) - 1 < DIGITS_DEFAULT) begin
                        out_byte = latched_digits[bytes_sent - 3'd1];
                        bits_sent = '0;
                        line_phase = PH_CLK_LOW;
                    end else begin
                        line_phase = PH_STOP_DATA_LOW;
                    end
                end
                PH_STOP_CLK_RELEASE: begin
                    clk_pull = 1'b0;
                    line_phase = PH_STOP_DATA_RELEASE;
                end
                PH_STOP_DATA_RELEASE: begin
                    dio_pull = 1'b0;
                    line_phase = PH_START;
                    if (frame_idx >= FRAME_CTRL) begin
                        frame_idx = FRAME_DATA;
                        seq_busy = 1'b0;
                        finished = 1'b1;
                    end else begin
                        frame_idx = frame_idx + 2'd1;
                    end
                end
                // First stop phase, and any phase value that cannot occur.
                default: begin
                    dio_pull = 1'b1;
                    line_phase = PH_STOP_CLK_RELEASE;
                end
            endcase
        end
        r.clk_low = clk_pull;
        r.dio_low = dio_pull;
        r.busy_res = seq_busy;
        r.accepted = took;
        r.nack_seen = nack_sticky;
        r.done_res = finished;
        return r;
    endfunction

    function automatic t_sdsw_item random_word(input logic kind);
        t_sdsw_item w;
        w.kind = kind;
        w.line_in = 1'($urandom_range(1));
        w.translate = 1'($urandom_range(1));
        for (int i = 0; i < DIGIT_INPUTS; i++) begin
            if (w.translate && $urandom_range(3) != 0)
                w.digit[i] = 8'($urandom_range(39));
            else
                w.digit[i] = 8'($urandom);
        end
        // Mostly short updates; the longest ones now and then.
        if ($urandom_range(4) != 0)
            w.digit_count = 3'($urandom_range(2));
        else
            w.digit_count = 3'($urandom_range(7, 3));
        w.position = 2'($urandom_range(3));
        return w;
    endfunction

    // Offers one word, waits for it to be taken and queues its expected result.
    // Called and returns just after a falling edge.
    task automatic send_word(input t_sdsw_item w, input logic typed, input t_sdsw_result want);
        t_sdsw_result predicted;
        logic counts;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind <= w.kind;
        i_line_in <= w.line_in;
        i_digit_zero <= w.digit[0];
        i_digit_one <= w.digit[1];
        i_digit_two <= w.digit[2];
        i_digit_three <= w.digit[3];
        i_translate <= w.translate;
        i_digit_count <= w.digit_count;
        i_position <= w.position;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        counts = (w.kind == KIND_REQUEST) ? !seq_busy : seq_busy;
        predicted = advance_line_sequencer(w);
        words_sent++;
        if (counts)
            live_words++;
        if (predicted.done_res) begin
            updates_finished++;
            if (predicted.nack_seen)
                nack_updates++;
        end
        line_words_due.push_back(typed ? want : predicted);
        @(negedge i_clk);
    endtask

    // One display update with random content; some ticks carry refused requests.
    task automatic run_update(input int ack_miss_pct, input int refuse_pct);
        t_sdsw_item w;
        send_word(random_word(KIND_REQUEST), 1'b0, '0);
        while (seq_busy) begin
            if ($urandom_range(99) < refuse_pct) begin
                w = random_word(KIND_REQUEST);
            end else begin
                w = random_word(KIND_TICK);
                w.line_in = ($urandom_range(99) < ack_miss_pct);
            end
            send_word(w, 1'b0, '0);
        end
    endtask

    // Stops offering words, waits until every result word is back, then lets
    // the pipeline run empty.
    task automatic settle_line();
        i_in_valid <= 1'b0;
        while (line_words_due.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic load_settings(input logic [REGISTERS-1:0][7:0] vals);
        for (int k = 0; k < REGISTERS; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= REGISTER_ORDER[k];
            i_cfg_data <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready)
                @(posedge i_clk);
            apply_register(REGISTER_ORDER[k], vals[k]);
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_offs++;
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Each taken result word is checked against the oldest expected one.
    always @(posedge i_clk) begin
        t_sdsw_result want;
        t_sdsw_result seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = '{o_clk_low, o_dio_low, o_busy_res, o_accepted, o_nack_seen, o_done_res};
            words_checked++;
            if (line_words_due.size() == 0) begin
                word_errors++;
                if (word_errors <= MAX_REPORTS)
                    $display("%0t: result word %b arrived with none expected", $time, seen);
            end else begin
                want = line_words_due.pop_front();
                if (seen.clk_low !== want.clk_low || seen.dio_low !== want.dio_low
                        || seen.busy_res !== want.busy_res
                        || seen.accepted !== want.accepted
                        || seen.nack_seen !== want.nack_seen
                        || seen.done_res !== want.done_res) begin
                    word_errors++;
                    if (word_errors <= MAX_REPORTS)
                        $display("%0t: word %0d clk/dio/busy/acc/nack/done expected %b, got %b",
                                 $time, words_checked, want, seen);
                end
            end
        end
    end

    // Watchdog.
    initial begin
        #(WATCHDOG_NS);
        $display("timeout with %0d result words outstanding", line_words_due.size());
        $display("end of test: mismatches");
        $finish;
    end

    // Stimulus.
    initial begin
        t_script_row row;
        t_sdsw_item w;
        logic [REGISTERS-1:0][7:0] vals;
        int quota;
        int miss_pick;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_kind = KIND_TICK;
        i_line_in = 1'b0;
        i_digit_zero = '0;
        i_digit_one = '0;
        i_digit_two = '0;
        i_digit_three = '0;
        i_translate = 1'b0;
        i_digit_count = '0;
        i_position = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BRIGHTNESS;
        i_cfg_data = '0;
        clear_line_model();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table at the reset settings.
        for (int n = 0; n < DIRECTED_ROWS; n++) begin
            row = DIRECTED_STEPS[n];
            w.kind = row.kind;
            w.line_in = row.line_in;
            w.digit = row.digits;
            w.translate = row.translate;
            w.digit_count = row.digit_count;
            w.position = row.position;
            if (row.repeats == 8'd0) begin
                while (seq_busy)
                    send_word(w, 1'b0, '0);
            end else begin
                repeat (row.repeats) send_word(w, row.typed, row.want);
            end
        end

        // Random updates, one setting and one idling pattern per phase.
        for (int p = 0; p < PHASES; p++) begin
            settle_line();
            if (p == 1) begin
                load_settings('0);
            end else if (p == 2) begin
                load_settings('1);
            end else if (p > 2) begin
                for (int k = 0; k < REGISTERS; k++)
                    vals[k] = 8'($urandom);
                load_settings(vals);
            end
            case (p % 4)
                1: begin sender_idle_pct = 77; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 77; end
                3: begin sender_idle_pct = 15; recv_stall_pct = 15; end
                default: begin sender_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            // Long result hold-off while words keep coming, so the input stalls.
            if (p == 4)
                hold_off_request = 1'b1;
            // Every phase runs at least one update; the total word count
            // tracks the item target across the phases.
            quota = ITEM_TARGET * (p + 1) / PHASES;
            do begin
                repeat ($urandom_range(2)) send_word(random_word(KIND_TICK), 1'b0, '0);
                miss_pick = $urandom_range(9);
                if (miss_pick < 6)
                    run_update(0, 3);
                else if (miss_pick < 9)
                    run_update(15, 3);
                else
                    run_update(100, 3);
            end while (words_sent < quota);
        end

        recv_stall_pct = 0;
        settle_line();
        if (line_words_due.size() != 0)
            word_errors++;
        $display("%0d words sent (%0d driving the sequencer), %0d updates done, %0d lost an ack",
                 words_sent, live_words, updates_finished, nack_updates);
        $display("%0d register settings, %0d long hold-offs, %0d words checked, %0d bad",
                 settings_loaded, hold_offs, words_checked, word_errors);
        if (word_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
sv/sdsw_pkg.sv
sv/sdsw_seq.sv
sv/segment_display_serial_writer.sv
verif/segment_display_serial_writer_tb.sv
